@@ rtl/cmv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmv_pkg
// Types and constants shared by the complex matrix-vector multiplier.
// ----------------------------------------------------------------------------
package cmv_pkg;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned NUM_VALS  = 2 * NUM_LANES;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SUM_W     = 64;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ROW  = 1'b1
  } op_e;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  localparam sum_t SAT_MAX = 64'sd2147483647;
  localparam sum_t SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic       valid;
    logic [1:0] row;
    logic       last;
  } meta_t;

endpackage

@@ rtl/cmv_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmv_if
// Valid/ready channels: row input, dot-product output, configuration write.
// ----------------------------------------------------------------------------
interface cmv_in_if;
  logic          valid;
  logic          ready;
  logic          op;
  cmv_pkg::data_t val0;
  cmv_pkg::data_t val1;
  cmv_pkg::data_t val2;
  cmv_pkg::data_t val3;
  cmv_pkg::data_t val4;
  cmv_pkg::data_t val5;
  cmv_pkg::data_t addend_re;
  cmv_pkg::data_t addend_im;

  modport source (output valid, op, val0, val1, val2, val3, val4, val5,
                  addend_re, addend_im, input ready);
  modport sink   (input valid, op, val0, val1, val2, val3, val4, val5,
                  addend_re, addend_im, output ready);
endinterface

interface cmv_out_if;
  logic           valid;
  logic           ready;
  cmv_pkg::data_t prod_re;
  cmv_pkg::data_t prod_im;
  logic [1:0]     row;
  logic           last_of_site;

  modport source (output valid, prod_re, prod_im, row, last_of_site, input ready);
  modport sink   (input valid, prod_re, prod_im, row, last_of_site, output ready);
endinterface

interface cmv_cfg_if;
  logic valid;
  logic ready;
  logic accumulate;

  modport source (output valid, accumulate, input ready);
  modport sink   (input valid, accumulate, output ready);
endinterface

@@ rtl/cmv_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmv_lane
// One complex element: four registered products, then the truncated
// complex product m * v.
// ----------------------------------------------------------------------------
module cmv_lane #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  cmv_pkg::data_t m_re_i,
  input  cmv_pkg::data_t m_im_i,
  input  cmv_pkg::data_t v_re_i,
  input  cmv_pkg::data_t v_im_i,
  output cmv_pkg::sum_t  re_o,
  output cmv_pkg::sum_t  im_o
);

  cmv_pkg::sum_t rr_q, ii_q, ri_q, ir_q;
  cmv_pkg::sum_t re_d, im_d, re_q, im_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q <= cmv_pkg::sum_t'(v_re_i) * cmv_pkg::sum_t'(m_re_i);
      ii_q <= cmv_pkg::sum_t'(v_im_i) * cmv_pkg::sum_t'(m_im_i);
      ri_q <= cmv_pkg::sum_t'(v_re_i) * cmv_pkg::sum_t'(m_im_i);
      ir_q <= cmv_pkg::sum_t'(v_im_i) * cmv_pkg::sum_t'(m_re_i);
    end
  end

  always_comb begin
    re_d = (rr_q >>> FRAC_BITS) - (ii_q >>> FRAC_BITS);
    im_d = (ri_q >>> FRAC_BITS) + (ir_q >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q <= re_d;
      im_q <= im_d;
    end
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

@@ rtl/cmv_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmv_merge
// Sum the lane results and the addend, saturate to 32 bits, register.
// ----------------------------------------------------------------------------
module cmv_merge (
  input  logic           clk_i,
  input  logic           en_i,
  input  cmv_pkg::sum_t  lane_re_i [cmv_pkg::NUM_LANES],
  input  cmv_pkg::sum_t  lane_im_i [cmv_pkg::NUM_LANES],
  input  cmv_pkg::sum_t  addend_re_i,
  input  cmv_pkg::sum_t  addend_im_i,
  output cmv_pkg::data_t prod_re_o,
  output cmv_pkg::data_t prod_im_o
);

  cmv_pkg::sum_t  sum_re, sum_im;
  cmv_pkg::data_t prod_re_d, prod_im_d, prod_re_q, prod_im_q;

  function automatic cmv_pkg::data_t sat32(input cmv_pkg::sum_t v);
    cmv_pkg::sum_t c;
    c = v;
    if (v > cmv_pkg::SAT_MAX) c = cmv_pkg::SAT_MAX;
    if (v < cmv_pkg::SAT_MIN) c = cmv_pkg::SAT_MIN;
    return c[cmv_pkg::DATA_W-1:0];
  endfunction

  always_comb begin
    sum_re = addend_re_i;
    sum_im = addend_im_i;
    for (int k = 0; k < cmv_pkg::NUM_LANES; k++) begin
      sum_re = sum_re + lane_re_i[k];
      sum_im = sum_im + lane_im_i[k];
    end
    prod_re_d = sat32(sum_re);
    prod_im_d = sat32(sum_im);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_re_q <= prod_re_d;
      prod_im_q <= prod_im_d;
    end
  end

  assign prod_re_o = prod_re_q;
  assign prod_im_o = prod_im_q;

endmodule

@@ rtl/complex_3x3_matrix_vector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_3x3_matrix_vector
// Complex 3x3 matrix times stored complex 3-vector, one matrix row per
// transaction, with optional accumulation and 32-bit saturation.
// ----------------------------------------------------------------------------
// Pipeline: product register, lane sum register, merge/saturate output
//   register; a row transaction's result is valid after the last of them.
// Throughput: one transaction per cycle, loads included (they give no result);
//   the whole pipeline holds while the output register is full and not taken.
// Reset: asynchronous active low; clears vector store, row counter,
//   accumulate and all valid flags.
module complex_3x3_matrix_vector #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cmv_cfg_if.sink   cfg_i,
  cmv_in_if.sink    in_i,
  cmv_out_if.source out_o
);

  logic            accumulate_q;
  cmv_pkg::data_t  vec_q [cmv_pkg::NUM_VALS];
  cmv_pkg::data_t  val_in [cmv_pkg::NUM_VALS];
  logic [1:0]      row_cnt_q, row_cnt_d;
  cmv_pkg::meta_t  meta1_d, meta1_q, meta2_q, meta3_q;
  cmv_pkg::sum_t   addend_re_d, addend_im_d;
  cmv_pkg::sum_t   addend_re1_q, addend_im1_q, addend_re2_q, addend_im2_q;
  cmv_pkg::sum_t   lane_re [cmv_pkg::NUM_LANES];
  cmv_pkg::sum_t   lane_im [cmv_pkg::NUM_LANES];
  logic            en, in_fire, is_row;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accumulate_q <= 1'b0;
    end else if (cfg_i.valid) begin
      accumulate_q <= cfg_i.accumulate;
    end
  end

  assign en          = !meta3_q.valid || out_o.ready;
  assign in_i.ready  = en;
  assign in_fire     = in_i.valid && en;
  assign is_row      = (cmv_pkg::op_e'(in_i.op) == cmv_pkg::OP_ROW);

  assign val_in[0] = in_i.val0;
  assign val_in[1] = in_i.val1;
  assign val_in[2] = in_i.val2;
  assign val_in[3] = in_i.val3;
  assign val_in[4] = in_i.val4;
  assign val_in[5] = in_i.val5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cmv_pkg::NUM_VALS; k++) vec_q[k] <= '0;
    end else if (in_fire && !is_row) begin
      for (int k = 0; k < cmv_pkg::NUM_VALS; k++) vec_q[k] <= val_in[k];
    end
  end

  always_comb begin
    row_cnt_d = row_cnt_q;
    if (in_fire) begin
      if (!is_row || row_cnt_q == cmv_pkg::ROW_LAST) begin
        row_cnt_d = cmv_pkg::ROW_FIRST;
      end else begin
        row_cnt_d = row_cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= cmv_pkg::ROW_FIRST;
    end else begin
      row_cnt_q <= row_cnt_d;
    end
  end

  always_comb begin
    meta1_d.valid = in_fire && is_row;
    meta1_d.row   = row_cnt_q;
    meta1_d.last  = (row_cnt_q == cmv_pkg::ROW_LAST);
    addend_re_d   = accumulate_q ? cmv_pkg::sum_t'(in_i.addend_re) : '0;
    addend_im_d   = accumulate_q ? cmv_pkg::sum_t'(in_i.addend_im) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      meta2_q <= '0;
      meta3_q <= '0;
    end else if (en) begin
      meta1_q <= meta1_d;
      meta2_q <= meta1_q;
      meta3_q <= meta2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      addend_re1_q <= addend_re_d;
      addend_im1_q <= addend_im_d;
      addend_re2_q <= addend_re1_q;
      addend_im2_q <= addend_im1_q;
    end
  end

  for (genvar g = 0; g < cmv_pkg::NUM_LANES; g++) begin : g_lane
    cmv_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .m_re_i (val_in[2*g]),
      .m_im_i (val_in[2*g+1]),
      .v_re_i (vec_q[2*g]),
      .v_im_i (vec_q[2*g+1]),
      .re_o   (lane_re[g]),
      .im_o   (lane_im[g])
    );
  end

  cmv_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (en),
    .lane_re_i   (lane_re),
    .lane_im_i   (lane_im),
    .addend_re_i (addend_re2_q),
    .addend_im_i (addend_im2_q),
    .prod_re_o   (out_o.prod_re),
    .prod_im_o   (out_o.prod_im)
  );

  assign out_o.valid        = meta3_q.valid;
  assign out_o.row          = meta3_q.row;
  assign out_o.last_of_site = meta3_q.last;

`ifndef ASSERT_OFF
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.row != 2'd3))
    else $error("result row index out of range");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.last_of_site == (out_o.row == cmv_pkg::ROW_LAST)))
    else $error("last_of_site disagrees with row");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input held while output is empty");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_row) |=> !meta1_q.valid)
    else $error("load transaction entered the pipeline");

  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_row) |=> (row_cnt_q == cmv_pkg::ROW_FIRST))
    else $error("row counter not cleared by load");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the complex 3x3 matrix-vector row multiplier.
// A directed table covers the value extremes, the wrap of the row counter,
// loads in mid-site, rows before the first load and the accumulate switch.
// Random phases follow, mostly load plus three rows, under each accumulate
// setting. Every result is compared with a local fixed-point predictor or
// with the expected result of a directed entry. Both sides idle in short
// bursts; the sink also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import cmv_pkg::*;

  localparam int unsigned FRAC_BITS  = 24;
  localparam int          DIR_N      = 22;
  localparam int          PHASE_N    = 6;
  localparam int          PHASE_LEN  = 250;
  localparam int          SETTLE     = 10;
  localparam int          HOLD_LEN   = 120;
  localparam longint      TIMEOUT_NS = 64'd8_000_000;

  localparam data_t MAXV = 32'sh7FFF_FFFF;
  localparam data_t MINV = 32'sh8000_0000;
  localparam data_t ONE  = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    op_e   op;
    data_t val0;
    data_t val1;
    data_t val2;
    data_t val3;
    data_t val4;
    data_t val5;
    data_t add_re;
    data_t add_im;
  } row_in_t;

  typedef struct packed {
    data_t      prod_re;
    data_t      prod_im;
    logic [1:0] row;
    logic       last;
  } dot_res_t;

  typedef struct packed {
    logic     acc;
    row_in_t  item;
    logic     typed;
    dot_res_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cmv_cfg_if cfg_if ();
  cmv_in_if  in_if ();
  cmv_out_if out_if ();

  complex_3x3_matrix_vector #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state
  logic       acc_mode = 1'b0;
  longint     vec_store[6] = '{default: 0};
  logic [1:0] row_idx = ROW_FIRST;

  dot_res_t   dot_q[$];
  dir_row_t   dir_tab[DIR_N];
  int         n_in = 0;
  int         err_cnt = 0;

  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic data_t sat32(input longint s);
    if (s > 64'sd2147483647) return MAXV;
    if (s < -64'sd2147483648) return MINV;
    return data_t'(s[31:0]);
  endfunction

  function automatic bit dot_step(input row_in_t it, output dot_res_t r);
    longint m[6];
    longint sre;
    longint sim;
    m[0] = it.val0;
    m[1] = it.val1;
    m[2] = it.val2;
    m[3] = it.val3;
    m[4] = it.val4;
    m[5] = it.val5;
    r = '0;
    if (it.op == OP_LOAD) begin
      for (int k = 0; k < 6; k++) vec_store[k] = m[k];
      row_idx = ROW_FIRST;
      return 1'b0;
    end
    sre = 0;
    sim = 0;
    for (int k = 0; k < 3; k++) begin
      sre += fx_mul(vec_store[2*k], m[2*k]) - fx_mul(vec_store[2*k+1], m[2*k+1]);
      sim += fx_mul(vec_store[2*k], m[2*k+1]) + fx_mul(vec_store[2*k+1], m[2*k]);
    end
    if (acc_mode) begin
      sre += longint'(it.add_re);
      sim += longint'(it.add_im);
    end
    r.prod_re = sat32(sre);
    r.prod_im = sat32(sim);
    r.row     = row_idx;
    r.last    = (row_idx == ROW_LAST);
    row_idx   = (row_idx >= ROW_LAST) ? ROW_FIRST : row_idx + 2'd1;
    return 1'b1;
  endfunction

  // scoreboard: compare results, then predict the accepted input
  always @(posedge clk_i) begin : mon
    row_in_t  it;
    dot_res_t got;
    dot_res_t want;
    dot_res_t pred;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) acc_mode = cfg_if.accumulate;
      if (out_if.valid && out_if.ready) begin
        got.prod_re = out_if.prod_re;
        got.prod_im = out_if.prod_im;
        got.row     = out_if.row;
        got.last    = out_if.last_of_site;
        if (dot_q.size() == 0) begin
          $error("unexpected result transaction: prod_re %0d, prod_im %0d",
                 got.prod_re, got.prod_im);
          err_cnt++;
        end else begin
          want = dot_q.pop_front();
          if (got.prod_re !== want.prod_re) begin
            $error("prod_re: expected %0d, actual %0d", want.prod_re, got.prod_re);
            err_cnt++;
          end
          if (got.prod_im !== want.prod_im) begin
            $error("prod_im: expected %0d, actual %0d", want.prod_im, got.prod_im);
            err_cnt++;
          end
          if (got.row !== want.row) begin
            $error("row: expected %0d, actual %0d", want.row, got.row);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last_of_site: expected %0d, actual %0d", want.last, got.last);
            err_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        it.op     = op_e'(in_if.op);
        it.val0   = in_if.val0;
        it.val1   = in_if.val1;
        it.val2   = in_if.val2;
        it.val3   = in_if.val3;
        it.val4   = in_if.val4;
        it.val5   = in_if.val5;
        it.add_re = in_if.addend_re;
        it.add_im = in_if.addend_im;
        if (dot_step(it, pred)) begin
          if (n_in < DIR_N && dir_tab[n_in].typed) dot_q.push_back(dir_tab[n_in].res);
          else dot_q.push_back(pred);
        end
        n_in++;
      end
    end
  end

  // result sink: random stalls, one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN - 1;
        out_if.ready <= 1'b0;
      end else if (quiet) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic dir_row_t dir_e(input logic acc, input op_e op,
                                     input data_t v0, input data_t v1, input data_t v2,
                                     input data_t v3, input data_t v4, input data_t v5,
                                     input data_t ar, input data_t ai, input logic typed,
                                     input data_t er, input data_t ei,
                                     input logic [1:0] row, input logic last);
    dir_row_t d;
    d.acc         = acc;
    d.item.op     = op;
    d.item.val0   = v0;
    d.item.val1   = v1;
    d.item.val2   = v2;
    d.item.val3   = v3;
    d.item.val4   = v4;
    d.item.val5   = v5;
    d.item.add_re = ar;
    d.item.add_im = ai;
    d.typed       = typed;
    d.res.prod_re = er;
    d.res.prod_im = ei;
    d.res.row     = row;
    d.res.last    = last;
    return d;
  endfunction

  function automatic data_t rnd_val();
    case ($urandom_range(0, 7))
      3:       return MAXV;
      4:       return MINV;
      5:       return data_t'($urandom_range(0, 32'h0400_0000)) - data_t'(32'h0200_0000);
      6: begin
        case ($urandom_range(0, 3))
          0:       return ONE;
          1:       return -ONE;
          2:       return '0;
          default: return -32'sd1;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input row_in_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= it.op;
    in_if.val0      <= it.val0;
    in_if.val1      <= it.val1;
    in_if.val2      <= it.val2;
    in_if.val3      <= it.val3;
    in_if.val4      <= it.val4;
    in_if.val5      <= it.val5;
    in_if.addend_re <= it.add_re;
    in_if.addend_im <= it.add_im;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_rand(input op_e op);
    row_in_t it;
    it.op     = op;
    it.val0   = rnd_val();
    it.val1   = rnd_val();
    it.val2   = rnd_val();
    it.val3   = rnd_val();
    it.val4   = rnd_val();
    it.val5   = rnd_val();
    it.add_re = rnd_val();
    it.add_im = rnd_val();
    send_item(it);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (dot_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic acc);
    cfg_if.valid      <= 1'b1;
    cfg_if.accumulate <= acc;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic cur_acc;
    int   sent;
    int   n;
    logic phase_acc[PHASE_N];

    rst_ni            <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.accumulate <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_LOAD;
    in_if.val0        <= '0;
    in_if.val1        <= '0;
    in_if.val2        <= '0;
    in_if.val3        <= '0;
    in_if.val4        <= '0;
    in_if.val5        <= '0;
    in_if.addend_re   <= '0;
    in_if.addend_im   <= '0;
    phase_acc = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    dir_tab[0]  = dir_e(0, OP_ROW, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV,
                        1, 0, 0, ROW_FIRST, 0);
    dir_tab[1]  = dir_e(0, OP_ROW, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV,
                        1, 0, 0, 2'd1, 0);
    dir_tab[2]  = dir_e(0, OP_ROW, 11, -22, 33, -44, 55, -66, 77, 88,
                        1, 0, 0, ROW_LAST, 1);
    dir_tab[3]  = dir_e(0, OP_ROW, ONE, ONE, ONE, ONE, ONE, ONE, 5, 5,
                        1, 0, 0, ROW_FIRST, 0);
    dir_tab[4]  = dir_e(0, OP_LOAD, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ROW_FIRST, 0);
    dir_tab[5]  = dir_e(0, OP_ROW, MAXV, MINV, 3, 4, 5, 6, MAXV, MAXV,
                        1, MAXV, MINV, ROW_FIRST, 0);
    dir_tab[6]  = dir_e(0, OP_LOAD, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0, 0,
                        0, 0, 0, ROW_FIRST, 0);
    dir_tab[7]  = dir_e(0, OP_ROW, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0, 0,
                        1, 0, MAXV, ROW_FIRST, 0);
    dir_tab[8]  = dir_e(0, OP_ROW, MINV, MINV, MINV, MINV, MINV, MINV, 0, 0,
                        1, 0, MINV, 2'd1, 0);
    dir_tab[9]  = dir_e(0, OP_ROW, 1234567, -7654321, ONE, -ONE, 99, MINV, 0, 0,
                        0, 0, 0, ROW_FIRST, 0);
    dir_tab[10] = dir_e(0, OP_ROW, -ONE, ONE, MINV, MAXV, -1, 1, 0, 0,
                        0, 0, 0, ROW_FIRST, 0);
    dir_tab[11] = dir_e(1, OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ROW_FIRST, 0);
    dir_tab[12] = dir_e(1, OP_ROW, MAXV, MINV, ONE, -1, 7, 9, MAXV, MINV,
                        1, MAXV, MINV, ROW_FIRST, 0);
    dir_tab[13] = dir_e(1, OP_ROW, MINV, MAXV, 1, 2, 3, 4, 1234, -5678,
                        1, 1234, -5678, 2'd1, 0);
    dir_tab[14] = dir_e(1, OP_LOAD, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0, 0,
                        0, 0, 0, ROW_FIRST, 0);
    dir_tab[15] = dir_e(1, OP_ROW, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
                        1, MAXV, MAXV, ROW_FIRST, 0);
    dir_tab[16] = dir_e(1, OP_ROW, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV,
                        1, MINV, MINV, 2'd1, 0);
    dir_tab[17] = dir_e(1, OP_ROW, 314159, -271828, ONE, 0, -ONE, 42, -1000, 1000,
                        0, 0, 0, ROW_FIRST, 0);
    dir_tab[18] = dir_e(1, OP_LOAD, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ROW_FIRST, 0);
    dir_tab[19] = dir_e(1, OP_ROW, 1, 1, 1, 1, 1, 1, 0, 0,
                        1, -1, -1, ROW_FIRST, 0);
    dir_tab[20] = dir_e(0, OP_ROW, 5, 6, 7, 8, 9, 10, MAXV, MAXV,
                        0, 0, 0, ROW_FIRST, 0);
    dir_tab[21] = dir_e(0, OP_ROW, MAXV, 0, MINV, 0, ONE, -ONE, MINV, MAXV,
                        0, 0, 0, ROW_FIRST, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_acc = 1'b0;
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].acc != cur_acc) begin
        drain();
        write_cfg(dir_tab[i].acc);
        cur_acc = dir_tab[i].acc;
      end
      send_item(dir_tab[i].item);
    end

    for (int p = 0; p < PHASE_N; p++) begin
      drain();
      write_cfg(phase_acc[p]);
      quiet = (p == PHASE_N - 1);
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_LEN) begin
        case ($urandom_range(0, 9))
          7: begin
            n = $urandom_range(1, 4);
            repeat (n) send_rand(OP_ROW);
            sent += n;
          end
          8: begin
            send_rand(OP_LOAD);
            send_rand(OP_ROW);
            send_rand(OP_LOAD);
            sent += 3;
          end
          9: begin
            send_rand(op_e'($urandom_range(0, 1)));
            sent += 1;
          end
          default: begin
            send_rand(OP_LOAD);
            repeat (3) send_rand(OP_ROW);
            sent += 4;
          end
        endcase
      end
    end

    drain();
    if (err_cnt == 0 && dot_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cmv_pkg.sv
rtl/cmv_if.sv
rtl/cmv_lane.sv
rtl/cmv_merge.sv
rtl/complex_3x3_matrix_vector.sv
tb/tb_top.sv
